[rtl/core/srpf_pkg.sv]
// ----------------------------------------------------------------------------
// srpf_pkg
// Shared types, constants and header word functions for the sensor reading
// packet framer.
// ----------------------------------------------------------------------------
package srpf_pkg;

   localparam int unsigned SecondsWidth  = 64;
   localparam int unsigned MicrosWidth   = 20;
   localparam int unsigned WaveWidth     = 64;
   localparam int unsigned WordWidth     = 32;
   localparam int unsigned ReadingsWidth = 11;
   localparam int unsigned SensorsWidth  = 7;
   localparam int unsigned PositionWidth = 10;
   localparam int unsigned SequenceWidth = 16;
   localparam int unsigned PhaseWidth    = 5;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = 11;

   localparam logic [ReadingsWidth-1:0] ReadingsReset = 11'd10;
   localparam logic [ReadingsWidth-1:0] ReadingsMax   = 11'd1024;
   localparam logic [SensorsWidth-1:0]  SensorsReset  = 7'd6;

   localparam logic [WordWidth-1:0] SyncWord       = 32'h0055_0055;
   localparam logic [WordWidth-1:0] PacketFixed    = 32'd84;
   localparam logic [WordWidth-1:0] ReadingBytes   = 32'd24;

   // word slots within the words caused by one item
   localparam logic [PhaseWidth-1:0] PH_SYNC      = 5'd0;
   localparam logic [PhaseWidth-1:0] PH_DEV       = 5'd1;
   localparam logic [PhaseWidth-1:0] PH_SENS      = 5'd9;
   localparam logic [PhaseWidth-1:0] PH_COUNT     = 5'd17;
   localparam logic [PhaseWidth-1:0] PH_SIZE      = 5'd18;
   localparam logic [PhaseWidth-1:0] PH_HSUM      = 5'd19;
   localparam logic [PhaseWidth-1:0] PH_READ      = 5'd20;
   localparam logic [PhaseWidth-1:0] PH_READ_LAST = 5'd25;
   localparam logic [PhaseWidth-1:0] PH_TRAIL     = 5'd26;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_READINGS = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SENSORS  = 2'd1;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic                 eop;
      logic                 last;
   } srpf_word_type;

   // fixed device id text zero padded to 32 bytes, little-endian words
   function automatic logic [WordWidth-1:0] dev_id_word(input logic [2:0] idx);
      logic [WordWidth-1:0] w;
      unique case (idx)
         3'd0:    w = 32'h756D_6973;
         3'd1:    w = 32'h6574_616C;
         3'd2:    w = 32'h6564_5F64;
         3'd3:    w = 32'h6563_6976;
         3'd4:    w = 32'h0000_0030;
         default: w = '0;
      endcase
      return w;
   endfunction

   // "sensorN" zero padded to 32 bytes, N in decimal
   function automatic logic [WordWidth-1:0] sensor_id_word(input logic [2:0] idx,
                                                          input logic [SensorsWidth-1:0] n);
      logic                    hund;
      logic [SensorsWidth-1:0] rem;
      logic [14:0]             prod;
      logic [3:0]              tens;
      logic [SensorsWidth-1:0] ones_full;
      logic [7:0]              ch;
      logic [7:0]              ct;
      logic [7:0]              co;
      logic [WordWidth-1:0]    w;
      hund      = (n >= 7'd100);
      rem       = hund ? n - 7'd100 : n;
      // rem < 100, so multiply by 205 and shift by 11 gives rem / 10
      prod      = 15'(rem) * 15'd205;
      tens      = prod[14:11];
      ones_full = rem - 7'(tens) * 7'd10;
      ch        = 8'h30 + 8'(hund);
      ct        = 8'h30 + 8'(tens);
      co        = 8'h30 + 8'(ones_full[3:0]);
      unique case (idx)
         3'd0: w = 32'h736E_6573;
         3'd1: begin
            if (hund) begin
               w = {ct, ch, 8'h72, 8'h6F};
            end else if (n >= 7'd10) begin
               w = {co, ct, 8'h72, 8'h6F};
            end else begin
               w = {8'h00, co, 8'h72, 8'h6F};
            end
         end
         3'd2:    w = hund ? {24'h0, co} : '0;
         default: w = '0;
      endcase
      return w;
   endfunction

endpackage

[rtl/core/srpf_word_seq.sv]
// ----------------------------------------------------------------------------
// srpf_word_seq
// Word sequencer: walks the word slots of the held item, one word per
// advance, and keeps the packet position, sensor index, sequence and sum.
// ----------------------------------------------------------------------------
module srpf_word_seq (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 advance,
   input  logic [srpf_pkg::SecondsWidth-1:0]    stamp_seconds,
   input  logic [srpf_pkg::MicrosWidth-1:0]     stamp_micros,
   input  logic [srpf_pkg::WaveWidth-1:0]       wavelength_raw,
   input  logic [srpf_pkg::ReadingsWidth-1:0]   readings_eff,
   input  logic [srpf_pkg::SensorsWidth:0]      sensors_eff,
   output srpf_pkg::srpf_word_type              word_out
);
   import srpf_pkg::*;

   logic [PhaseWidth-1:0]    phase_ff, phase_in;
   logic [PositionWidth-1:0] pos_ff, pos_in;
   logic [SensorsWidth-1:0]  sensor_ff, sensor_in;
   logic [SequenceWidth-1:0] seq_ff, seq_in;
   logic [WordWidth-1:0]     sum_ff, sum_in;

   logic [PhaseWidth-1:0]    cur_phase;
   logic [PhaseWidth-1:0]    sub_idx;
   logic                     packet_end;
   logic [WordWidth-1:0]     word;

   // skip the header when the packet is already open
   assign cur_phase  = (phase_ff == PH_SYNC && pos_ff != '0) ? PH_READ : phase_ff;
   assign packet_end = ({1'b0, pos_ff} + 11'd1) >= readings_eff;

   always_comb begin
      sub_idx = '0;
      word    = '0;
      priority if (cur_phase == PH_SYNC) begin
         word = SyncWord;
      end else if (cur_phase < PH_SENS) begin
         sub_idx = cur_phase - PH_DEV;
         word    = dev_id_word(sub_idx[2:0]);
      end else if (cur_phase < PH_COUNT) begin
         sub_idx = cur_phase - PH_SENS;
         word    = sensor_id_word(sub_idx[2:0], sensor_ff);
      end else if (cur_phase == PH_COUNT) begin
         word = {5'd0, readings_eff, seq_ff};
      end else if (cur_phase == PH_SIZE) begin
         word = PacketFixed + ReadingBytes * 32'(readings_eff);
      end else if (cur_phase == PH_HSUM || cur_phase == PH_TRAIL) begin
         word = sum_ff;
      end else begin
         sub_idx = cur_phase - PH_READ;
         unique case (sub_idx[2:0])
            3'd0:    word = stamp_seconds[31:0];
            3'd1:    word = stamp_seconds[63:32];
            3'd2:    word = {12'd0, stamp_micros};
            3'd4:    word = wavelength_raw[31:0];
            3'd5:    word = wavelength_raw[63:32];
            default: word = '0;
         endcase
      end
   end

   assign word_out.word = word;
   assign word_out.eop  = (cur_phase == PH_TRAIL);
   assign word_out.last = (cur_phase == PH_TRAIL) ||
                          (cur_phase == PH_READ_LAST && !packet_end);

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      sensor_in = sensor_ff;
      seq_in    = seq_ff;
      sum_in    = sum_ff;
      if (advance) begin
         sum_in   = ((cur_phase == PH_SYNC) ? '0 : sum_ff) + word;
         phase_in = word_out.last ? PH_SYNC : cur_phase + 5'd1;
         if (word_out.eop) begin
            pos_in = '0;
            if (({1'b0, sensor_ff} + 8'd1) >= sensors_eff) begin
               sensor_in = '0;
               seq_in    = seq_ff + 16'd1;
            end else begin
               sensor_in = sensor_ff + 7'd1;
            end
         end else if (word_out.last) begin
            pos_in = pos_ff + 10'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC;
         pos_ff    <= '0;
         sensor_ff <= '0;
         seq_ff    <= '0;
         sum_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         sensor_ff <= sensor_in;
         seq_ff    <= seq_in;
         sum_ff    <= sum_in;
      end
   end

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PH_TRAIL)
      else $error("word slot out of range");

   a_trailer_closes: assert property (@(posedge clock) disable iff (reset)
      advance && word_out.eop |=> pos_ff == '0 && phase_ff == PH_SYNC)
      else $error("packet not closed after trailer");

   a_phase_steps: assert property (@(posedge clock) disable iff (reset)
      advance && !word_out.last |=> phase_ff == $past(cur_phase) + 5'd1)
      else $error("word slot skipped");

   a_sum_restart: assert property (@(posedge clock) disable iff (reset)
      advance && cur_phase == PH_SYNC |=> sum_ff == SyncWord)
      else $error("running sum not restarted at header");

endmodule

[rtl/core/sensor_reading_packet_framer.sv]
// ----------------------------------------------------------------------------
// sensor_reading_packet_framer
// Frames timestamped readings into sensor packets of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one reading per item (seconds, micros, raw double bits).
//   rsp_*  : one packet word per item, with end_of_packet on the trailing
//            checksum and last_for_item on the final word of each reading.
//   csr_*  : register writes (index 0 readings per packet, index 1 sensor
//            count), taken in every cycle outside reset; write only while idle.
// An accepted reading sits in an item register; the word sequencer then
// places one word per cycle into the output register unless the receiver
// stalls; the first word passes the item register, then the output register.
// A reading gives 6 words, 26 when it opens a packet (20 header words),
// plus 1 for the trailing checksum. The next reading is taken in the cycle
// its predecessor's last word is produced, so words stream without gaps.
// Reset clears the packet position, sensor index, sequence and sum and
// restores the register defaults. When the receiver stalls, the output word
// holds and the sequencer waits; no word is dropped.
// ----------------------------------------------------------------------------
module sensor_reading_packet_framer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [srpf_pkg::SecondsWidth-1:0]    req_stamp_seconds,
   input  logic [srpf_pkg::MicrosWidth-1:0]     req_stamp_micros,
   input  logic [srpf_pkg::WaveWidth-1:0]       req_wavelength_raw,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [srpf_pkg::WordWidth-1:0]       rsp_packet_word,
   output logic                                 rsp_end_of_packet,
   output logic                                 rsp_last_for_item,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srpf_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [srpf_pkg::CsrDataWidth-1:0]    csr_data
);
   import srpf_pkg::*;

   logic [ReadingsWidth-1:0] readings_ff;
   logic [SensorsWidth-1:0]  sensors_ff;
   logic [ReadingsWidth-1:0] readings_eff;
   logic [SensorsWidth:0]    sensors_eff;

   logic                     item_valid_ff;
   logic [SecondsWidth-1:0]  seconds_ff;
   logic [MicrosWidth-1:0]   micros_ff;
   logic [WaveWidth-1:0]     wave_ff;

   logic                     out_valid_ff;
   srpf_word_type            out_ff;
   srpf_word_type            seq_word;
   logic                     advance;
   logic                     accept;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         readings_ff <= ReadingsReset;
         sensors_ff  <= SensorsReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_READINGS: readings_ff <= csr_data[ReadingsWidth-1:0];
            CSR_SENSORS:  sensors_ff  <= csr_data[SensorsWidth-1:0];
            default: ;
         endcase
      end
   end

   // clamp the count registers into their usable range
   assign readings_eff = (readings_ff == '0)         ? 11'd1 :
                         (readings_ff > ReadingsMax) ? ReadingsMax : readings_ff;
   assign sensors_eff  = (sensors_ff == '0) ? 8'd1 : {1'b0, sensors_ff};

   assign advance   = item_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !reset && (!item_valid_ff || (advance && seq_word.last));
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (accept) begin
         item_valid_ff <= 1'b1;
      end else if (advance && seq_word.last) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         seconds_ff <= req_stamp_seconds;
         micros_ff  <= req_stamp_micros;
         wave_ff    <= req_wavelength_raw;
      end
   end

   srpf_word_seq u_word_seq (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .stamp_seconds  (seconds_ff),
      .stamp_micros   (micros_ff),
      .wavelength_raw (wave_ff),
      .readings_eff   (readings_eff),
      .sensors_eff    (sensors_eff),
      .word_out       (seq_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= seq_word;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_packet_word   = out_ff.word;
   assign rsp_end_of_packet = out_ff.eop;
   assign rsp_last_for_item = out_ff.last;

   a_take_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && item_valid_ff |-> advance && seq_word.last)
      else $error("item taken while previous item still producing words");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !advance)
      else $error("stalled output word overwritten");

   a_word_follows: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("produced word not presented");

endmodule

[dv/sensor_reading_packet_framer_tb.sv]
// ----------------------------------------------------------------------------
// sensor_reading_packet_framer_tb
// Streams timestamped readings into the framer under several readings-per-
// packet and sensor-count settings and compares every packet word, its
// end-of-packet flag and its last-for-item flag with a packet builder kept in
// the bench. Both channels idle at random, except in the final phase.
// ----------------------------------------------------------------------------
module sensor_reading_packet_framer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import srpf_pkg::*;

   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [WordWidth-1:0] SYNC_PATTERN      = 32'h0055_0055;
   localparam int unsigned          HEADER_BYTES      = 84;
   localparam int unsigned          BYTES_PER_READING = 24;
   localparam int unsigned          MAX_READINGS      = 1024;
   localparam int unsigned          RANDOM_READINGS   = 230;
   localparam int unsigned          DRAIN_LIMIT       = 4000;

   typedef struct {
      logic [SecondsWidth-1:0] seconds;
      logic [MicrosWidth-1:0]  micros;
      logic [WaveWidth-1:0]    wave;
   } stamped_reading_t;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [SecondsWidth-1:0]  req_stamp_seconds = '0;
   logic [MicrosWidth-1:0]   req_stamp_micros = '0;
   logic [WaveWidth-1:0]     req_wavelength_raw = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [WordWidth-1:0]     rsp_packet_word;
   logic                     rsp_end_of_packet;
   logic                     rsp_last_for_item;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   sensor_reading_packet_framer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stamp_seconds  (req_stamp_seconds),
      .req_stamp_micros   (req_stamp_micros),
      .req_wavelength_raw (req_wavelength_raw),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_packet_word    (rsp_packet_word),
      .rsp_end_of_packet  (rsp_end_of_packet),
      .rsp_last_for_item  (rsp_last_for_item),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // packet builder state
   logic [ReadingsWidth-1:0] cfg_readings = ReadingsReset;
   logic [SensorsWidth-1:0]  cfg_sensors  = SensorsReset;
   logic [PositionWidth-1:0] reading_slot = '0;
   logic [SensorsWidth-1:0]  sensor_slot  = '0;
   logic [SequenceWidth-1:0] packet_seq   = '0;
   logic [WordWidth-1:0]     word_sum     = '0;
   string                    device_name  = {"simulated_", "device0"};

   stamped_reading_t pending_readings[$];
   srpf_word_type    item_words[$];
   srpf_word_type    expected_words[$];

   bit          calm = 1'b0;
   bit          holding = 1'b0;
   int unsigned error_count = 0;
   int unsigned readings_taken = 0;
   int unsigned words_checked = 0;
   int unsigned packets_seen = 0;
   int unsigned register_writes = 0;
   int unsigned random_queued = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d words outstanding", expected_words.size());
      $display("DONE: errors detected");
      $finish;
   end

   task automatic log_error(input string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // bytes of a zero-padded text field, little-endian within each word
   function automatic logic [WordWidth-1:0] text_word(input string text, input int idx);
      logic [WordWidth-1:0] w;
      int                   k;
      w = '0;
      for (k = 0; k < 4; k++) begin
         if (4 * idx + k < text.len()) w[8*k +: 8] = text[4*idx+k];
      end
      return w;
   endfunction

   function automatic void put_word(input logic [WordWidth-1:0] w, input logic eop);
      srpf_word_type e;
      e.word = w;
      e.eop  = eop;
      e.last = 1'b0;
      item_words = {item_words, e};
      word_sum += w;
   endfunction

   function automatic void frame_reading(input stamped_reading_t rd);
      int unsigned   n_readings;
      int unsigned   n_sensors;
      int            i;
      string         id_text;
      item_words.delete();
      if (cfg_readings == 0) n_readings = 1;
      else if (cfg_readings > MAX_READINGS) n_readings = MAX_READINGS;
      else n_readings = cfg_readings;
      n_sensors = (cfg_sensors == 0) ? 1 : cfg_sensors;

      if (reading_slot == 0) begin
         word_sum = '0;
         put_word(SYNC_PATTERN, 1'b0);
         for (i = 0; i < 8; i++) put_word(text_word(device_name, i), 1'b0);
         id_text = $sformatf("sensor%0d", sensor_slot);
         for (i = 0; i < 8; i++) put_word(text_word(id_text, i), 1'b0);
         put_word({n_readings[15:0], packet_seq}, 1'b0);
         put_word(HEADER_BYTES + BYTES_PER_READING * n_readings, 1'b0);
         put_word(word_sum, 1'b0);
      end

      put_word(rd.seconds[31:0], 1'b0);
      put_word(rd.seconds[63:32], 1'b0);
      put_word({12'b0, rd.micros}, 1'b0);
      put_word('0, 1'b0);
      put_word(rd.wave[31:0], 1'b0);
      put_word(rd.wave[63:32], 1'b0);

      if (reading_slot + 1 >= n_readings) begin
         put_word(word_sum, 1'b1);
         reading_slot = '0;
         if (sensor_slot + 1 >= n_sensors) begin
            sensor_slot = '0;
            packet_seq  = packet_seq + 1'b1;
         end else begin
            sensor_slot = sensor_slot + 1'b1;
         end
      end else begin
         reading_slot = reading_slot + 1'b1;
      end

      item_words[item_words.size()-1].last = 1'b1;
      expected_words = {expected_words, item_words};
   endfunction

   function automatic void apply_register(input logic [CsrIndexWidth-1:0] idx,
                                          input logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_READINGS: cfg_readings = data;
         CSR_SENSORS:  cfg_sensors  = data[SensorsWidth-1:0];
         default:      ;
      endcase
   endfunction

   // reading driver
   always @(posedge clock) begin
      stamped_reading_t rd;
      int               gap_left;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && req_ready) begin
            rd.seconds = req_stamp_seconds;
            rd.micros  = req_stamp_micros;
            rd.wave    = req_wavelength_raw;
            frame_reading(rd);
            readings_taken++;
            holding = 1'b0;
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0 && !calm) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_readings.size() != 0) begin
               rd = pending_readings.pop_front();
               holding = 1'b1;
               req_valid          <= 1'b1;
               req_stamp_seconds  <= rd.seconds;
               req_stamp_micros   <= rd.micros;
               req_wavelength_raw <= rd.wave;
               if (!calm && $urandom_range(0, 3) == 0) gap_left = $urandom_range(1, 10);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // word monitor and receiver stalls
   always @(posedge clock) begin
      srpf_word_type want;
      int            stall_left;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_checked++;
            if (rsp_end_of_packet) packets_seen++;
            if (expected_words.size() == 0) begin
               log_error($sformatf("unexpected word %h", rsp_packet_word));
            end else begin
               want = expected_words.pop_front();
               if (rsp_packet_word !== want.word)
                  log_error($sformatf("packet_word got %h want %h",
                                      rsp_packet_word, want.word));
               if (rsp_end_of_packet !== want.eop)
                  log_error($sformatf("end_of_packet got %b want %b on word %h",
                                      rsp_end_of_packet, want.eop, want.word));
               if (rsp_last_for_item !== want.last)
                  log_error($sformatf("last_for_item got %b want %b on word %h",
                                      rsp_last_for_item, want.last, want.word));
            end
         end
         if (stall_left > 0 && !calm) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 10);
         end
      end
   end

   function automatic stamped_reading_t random_reading();
      stamped_reading_t rd;
      rd.seconds = {$urandom, $urandom};
      rd.micros  = ($urandom_range(0, 7) == 0) ? MicrosWidth'($urandom)
                                               : MicrosWidth'($urandom_range(0, 999999));
      rd.wave    = {$urandom, $urandom};
      return rd;
   endfunction

   task automatic queue_reading(input logic [SecondsWidth-1:0] seconds,
                                input logic [MicrosWidth-1:0] micros,
                                input logic [WaveWidth-1:0] wave);
      stamped_reading_t rd;
      rd.seconds = seconds;
      rd.micros  = micros;
      rd.wave    = wave;
      pending_readings = {pending_readings, rd};
   endtask

   task automatic queue_random(input int unsigned count);
      repeat (count) pending_readings = {pending_readings, random_reading()};
   endtask

   // wait until every reading is taken and every word has come out
   task automatic settle();
      int unsigned waited;
      while (pending_readings.size() != 0 || holding) @(posedge clock);
      waited = 0;
      while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_words.size() != 0) begin
         log_error($sformatf("%0d words never produced", expected_words.size()));
         expected_words.delete();
      end
      repeat (4) @(posedge clock);
   endtask

   // call right after a rising edge; returns right after one
   task automatic write_register(input logic [CsrIndexWidth-1:0] idx,
                                 input logic [CsrDataWidth-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_register(idx, data);
      register_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int unsigned n_items;
      int unsigned pick;
      logic [CsrDataWidth-1:0] readings_val;
      logic [CsrDataWidth-1:0] sensors_val;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes under the reset settings, completing one packet
      queue_reading('0, '0, '0);
      queue_reading('1, 20'd999999, '1);
      queue_reading(64'h8000_0000_0000_0001, 20'hFFFFF, 64'h5555_5555_5555_5555);
      queue_reading(64'hAAAA_AAAA_AAAA_AAAA, 20'h55555, 64'hAAAA_AAAA_AAAA_AAAA);
      queue_reading(64'h0000_0001_FFFF_FFFF, 20'd1, 64'h7FF0_0000_0000_0000);
      queue_random(5);
      settle();

      // zero registers act as one reading and one sensor
      write_register(CSR_READINGS, '0);
      write_register(CSR_SENSORS, '0);
      queue_random(2);
      settle();

      // oversized readings count saturates; then shrink it mid-packet
      write_register(CSR_READINGS, '1);
      write_register(CSR_SENSORS, 11'd3);
      queue_random(3);
      settle();
      write_register(CSR_SPARE_A, '1);
      write_register(CSR_SPARE_B, 11'h2A5);
      write_register(CSR_READINGS, 11'd2);
      queue_random(2);
      settle();

      // largest legal packet, partly filled, then cut short
      write_register(CSR_READINGS, 11'd1024);
      write_register(CSR_SENSORS, 11'd100);
      queue_random(5);
      settle();
      write_register(CSR_READINGS, 11'd3);
      queue_random(3);
      settle();
      random_queued = 25;

      // one reading per packet across every sensor id
      write_register(CSR_READINGS, 11'd1);
      write_register(CSR_SENSORS, 11'h7FF);
      queue_random(140);
      settle();
      random_queued += 140;

      while (random_queued < RANDOM_READINGS) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) readings_val = CsrDataWidth'($urandom_range(1, 6));
         else if (pick < 8) readings_val = CsrDataWidth'($urandom_range(0, 12));
         else if (pick == 8) readings_val = CsrDataWidth'($urandom_range(0, 2047));
         else readings_val = ($urandom_range(0, 1) == 0) ? 11'd1024 : 11'd2047;
         sensors_val = {4'($urandom), ($urandom_range(0, 3) == 0)
                                      ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(1, 4))};
         pick = $urandom_range(0, 3);
         if (pick != 1) write_register(CSR_READINGS, readings_val);
         if (pick != 2) write_register(CSR_SENSORS, sensors_val);
         if (pick == 3) write_register(CSR_SPARE_A, CsrDataWidth'($urandom));

         n_items = $urandom_range(8, 24);
         if (RANDOM_READINGS - random_queued <= 24) begin
            // final stretch runs without idling
            calm = 1'b1;
            n_items = RANDOM_READINGS - random_queued;
         end
         queue_random(n_items);
         random_queued += n_items;
         settle();
      end

      repeat (8) @(posedge clock);

      $display("Checked %0d words from %0d readings, %0d packets closed",
               words_checked, readings_taken, packets_seen);
      $display("Register writes: %0d, final sequence number %0d",
               register_writes, packet_seq);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/core/srpf_pkg.sv
rtl/core/srpf_word_seq.sv
rtl/core/sensor_reading_packet_framer.sv
dv/sensor_reading_packet_framer_tb.sv
